[rtl/assert_macros.svh]
// Assertion macros shared by the servo PWM mux RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, masked while reset is asserted.
`define ISPWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Invariant that must hold at every sampled edge.
`define ISPWM_ASSERT_ALWAYS(lbl, expr, msg) \
  `ISPWM_ASSERT(lbl, 1'b1 |-> (expr), msg)

`endif

[rtl/ispwm_pkg.sv]
// Shared types, codes and constants for the servo PWM mux.
`timescale 1ns / 1ps

package ispwm_pkg;

  // Field and register widths
  localparam int BYTE_W     = 8;
  localparam int OP_W       = 2;
  localparam int DEV_ADDR_W = 7;
  localparam int TIMEOUT_W  = 24;
  localparam int TOP_W      = 16;
  localparam int BASE_W     = 16;
  localparam int SPAN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Default structure
  localparam int CHANNELS_DEF   = 6;
  localparam int COUNT_BITS_DEF = 16;

  // Register reset values
  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RST = 7'd8;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 24'd20000;
  localparam logic [TOP_W-1:0]      TOP_RST      = 16'd20000;
  localparam logic [BASE_W-1:0]     BASE_RST     = 16'd1000;
  localparam logic [SPAN_W-1:0]     SPAN_RST     = 16'd1000;

  // Reply codes and control bit position
  localparam logic [BYTE_W-1:0] REPLY_GOOD = 8'd65;  // 'A'
  localparam logic [BYTE_W-1:0] REPLY_BAD  = 8'd78;  // 'N'
  localparam int                RADIO_BIT  = 0;

  localparam logic [TIMEOUT_W-1:0] SINCE_MAX = '1;

  // Bus event kinds
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_ADDR_WR = 2'd1,
    OP_ADDR_RD = 2'd2,
    OP_DATA    = 2'd3
  } op_e;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEV_ADDR = 3'd0,
    CFG_TIMEOUT  = 3'd1,
    CFG_TOP      = 3'd2,
    CFG_BASE     = 3'd3,
    CFG_SPAN     = 3'd4
  } cfg_idx_e;

  // Receiver status for one beat
  typedef struct packed {
    logic              reply_valid;
    logic [BYTE_W-1:0] reply_byte;
    logic              load;
  } ispwm_rx_stat_t;

endpackage

[rtl/ispwm_rx.sv]
// Packet receiver: byte capture, running checksum, reply and pulse width mapping.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ispwm_rx import ispwm_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  op_e                                  op_i,
  input  logic [BYTE_W-1:0]                    byte_i,
  input  logic [DEV_ADDR_W-1:0]                dev_addr_i,
  input  logic [BASE_W-1:0]                    base_i,
  input  logic [SPAN_W-1:0]                    span_i,
  output ispwm_rx_stat_t                       stat_o,
  output logic [CHANNELS-1:0][COUNT_BITS-1:0]  widths_o,
  output logic                                 ctrl_bit_d_o
);

  localparam int PKT_LEN = CHANNELS + 2;
  localparam int PH_W    = $clog2(PKT_LEN + 1);
  localparam int PROD_W  = BYTE_W + SPAN_W;
  localparam int SUM_W   = BASE_W + 1;

  logic [PH_W-1:0]   phase_q, phase_d;
  logic              recv_q, recv_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [PKT_LEN-1:0][BYTE_W-1:0] bytes_q, bytes_d;

  // Decode one bus event
  always_comb begin
    phase_d = phase_q;
    recv_d  = recv_q;
    xor_d   = xor_q;
    bytes_d = bytes_q;
    stat_o  = '0;
    if (step_i) begin
      unique case (op_i)
        OP_ADDR_WR: begin
          phase_d = '0;
          if (byte_i == {dev_addr_i, 1'b0}) begin
            recv_d = 1'b1;
          end
        end
        OP_ADDR_RD: begin
          if (recv_q) begin
            stat_o.reply_valid = 1'b1;
            if (xor_q == bytes_q[PKT_LEN-1]) begin
              stat_o.load       = 1'b1;
              stat_o.reply_byte = REPLY_GOOD;
            end else begin
              stat_o.reply_byte = REPLY_BAD;
            end
            recv_d  = 1'b0;
            phase_d = PH_W'(PKT_LEN);
          end
        end
        OP_DATA: begin
          if (recv_q && (phase_q < PH_W'(PKT_LEN))) begin
            for (int i = 0; i < PKT_LEN; i++) begin
              if (phase_q == PH_W'(i)) begin
                bytes_d[i] = byte_i;
              end
            end
            if (phase_q == '0) begin
              xor_d = byte_i;
            end else if (phase_q < PH_W'(PKT_LEN - 1)) begin
              xor_d = xor_q ^ byte_i;
            end
            phase_d = phase_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign ctrl_bit_d_o = bytes_d[0][RADIO_BIT];

  // Hold packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      recv_q  <= 1'b0;
      xor_q   <= '0;
      bytes_q <= '0;
    end else begin
      phase_q <= phase_d;
      recv_q  <= recv_d;
      xor_q   <= xor_d;
      bytes_q <= bytes_d;
    end
  end

  // Map each channel byte to a pulse width, saturating at the counter range
  for (genvar g = 0; g < CHANNELS; g++) begin : g_width
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    assign prod = bytes_q[g+1] * span_i;
    assign sum  = {1'b0, base_i} + {1'b0, prod[PROD_W-1:BYTE_W]};
    if (COUNT_BITS >= SUM_W) begin : g_wide
      assign widths_o[g] = COUNT_BITS'(sum);
    end else begin : g_sat
      assign widths_o[g] = (sum > SUM_W'({COUNT_BITS{1'b1}})) ? '1 : sum[COUNT_BITS-1:0];
    end
  end

  `ISPWM_ASSERT_ALWAYS(a_phase_range, phase_q <= PH_W'(PKT_LEN),
                       "packet phase past end of packet")
  `ISPWM_ASSERT(a_read_ends_rx, step_i && (op_i == OP_ADDR_RD) |=> !recv_q,
                "receiving still set after read address")
  `ISPWM_ASSERT(a_load_needs_rx, stat_o.load |-> recv_q && stat_o.reply_valid,
                "width load without an open packet")

endmodule

[rtl/ispwm_pwm.sv]
// Period counter, pin levels, active/shadow widths and packet timeout counter.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ispwm_pwm import ispwm_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 tick_i,
  input  logic                                 load_i,
  input  logic [CHANNELS-1:0][COUNT_BITS-1:0]  widths_i,
  input  logic [TOP_W-1:0]                     period_top_i,
  input  logic [TIMEOUT_W-1:0]                 timeout_i,
  output logic [CHANNELS-1:0]                  pins_o,
  output logic                                 alive_d_o
);

  localparam int CMP_W = (COUNT_BITS > TOP_W) ? COUNT_BITS : TOP_W;

  logic [COUNT_BITS-1:0]                cnt_q, cnt_d, cnt_inc;
  logic [CHANNELS-1:0]                  pins_q, pins_d;
  logic [CHANNELS-1:0][COUNT_BITS-1:0]  active_q, active_d;
  logic [CHANNELS-1:0][COUNT_BITS-1:0]  shadow_q, shadow_d;
  logic [TIMEOUT_W-1:0]                 since_q, since_d;

  assign cnt_inc = cnt_q + 1'b1;

  // Advance the period on a tick, load shadows on a good packet
  always_comb begin
    cnt_d    = cnt_q;
    pins_d   = pins_q;
    active_d = active_q;
    shadow_d = shadow_q;
    since_d  = since_q;
    if (tick_i) begin
      cnt_d = cnt_inc;
      for (int i = 0; i < CHANNELS; i++) begin
        if (cnt_inc == active_q[i]) begin
          pins_d[i] = 1'b0;
        end
      end
      if (CMP_W'(cnt_inc) == CMP_W'(period_top_i)) begin
        pins_d   = '1;
        active_d = shadow_q;
        cnt_d    = '0;
      end
      if (since_q != SINCE_MAX) begin
        since_d = since_q + 1'b1;
      end
    end
    if (load_i) begin
      shadow_d = widths_i;
      since_d  = '0;
    end
  end

  assign pins_o    = pins_q;
  assign alive_d_o = since_d < timeout_i;

  // Hold timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      pins_q   <= '1;
      active_q <= '0;
      shadow_q <= '0;
      since_q  <= '0;
    end else begin
      cnt_q    <= cnt_d;
      pins_q   <= pins_d;
      active_q <= active_d;
      shadow_q <= shadow_d;
      since_q  <= since_d;
    end
  end

  `ISPWM_ASSERT(a_load_clears_since, load_i |=> since_q == '0,
                "timeout counter not cleared by good packet")
  `ISPWM_ASSERT(a_idle_holds_cnt, !tick_i |=> cnt_q == $past(cnt_q),
                "period counter moved without a tick")

endmodule

[rtl/i2c_servo_pwm_mux.sv]
// Top level: I2C event stream to six-channel servo PWM with radio mux control.
//
// Channel  Dir  Handshake                  Contents
// s_axis   in   s_axis_tvalid/tready       tuser: operation; tdata: bus_byte
// m_axis   out  m_axis_tvalid/tready       tuser: reply_valid; tdata: reply, pins, radio_off
// cfg      in   cfg_valid_i/cfg_ready_o    cfg_index_i selects register, cfg_data_i value
//
// One beat per cycle while s_axis_tready is high, its result registered in output or skid.
// Each beat passes through one combinational pass: a byte-by-span product and
// add for the widths, plus the period counter compares.
// A two-entry output stage (register plus skid) keeps input open while a result waits.
// Reset is asynchronous, active low, and needs no clearing pass; cfg_ready_o is always high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_servo_pwm_mux import ispwm_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input beats
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] bus_byte
  input  logic [OP_W-1:0]       s_axis_tuser,  // [1:0] operation
  // result beats
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] reply_byte, [8+:CHANNELS] pwm_pins, [8+CHANNELS] radio_off, rest zero
  output logic [((BYTE_W+CHANNELS+1+7)/8)*8-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,  // [0] reply_valid
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int OUT_DW = ((BYTE_W + CHANNELS + 1 + 7) / 8) * 8;

  // Configuration registers
  logic [DEV_ADDR_W-1:0] dev_addr_q;
  logic [TIMEOUT_W-1:0]  timeout_q;
  logic [TOP_W-1:0]      top_q;
  logic [BASE_W-1:0]     base_q;
  logic [SPAN_W-1:0]     span_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RST;
      timeout_q  <= TIMEOUT_RST;
      top_q      <= TOP_RST;
      base_q     <= BASE_RST;
      span_q     <= SPAN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEV_ADDR: dev_addr_q <= cfg_data_i[DEV_ADDR_W-1:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i[TIMEOUT_W-1:0];
        CFG_TOP:      top_q      <= cfg_data_i[TOP_W-1:0];
        CFG_BASE:     base_q     <= cfg_data_i[BASE_W-1:0];
        CFG_SPAN:     span_q     <= cfg_data_i[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beat
  logic step;
  op_e  op;

  assign step = s_axis_tvalid && s_axis_tready;
  assign op   = op_e'(s_axis_tuser);

  ispwm_rx_stat_t                      rx_stat;
  logic [CHANNELS-1:0][COUNT_BITS-1:0] widths;
  logic                                ctrl_bit_d;
  logic [CHANNELS-1:0]                 pins;
  logic                                alive_d;

  ispwm_rx #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .op_i         (op),
    .byte_i       (s_axis_tdata),
    .dev_addr_i   (dev_addr_q),
    .base_i       (base_q),
    .span_i       (span_q),
    .stat_o       (rx_stat),
    .widths_o     (widths),
    .ctrl_bit_d_o (ctrl_bit_d)
  );

  ispwm_pwm #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_pwm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (step && (op == OP_TICK)),
    .load_i       (rx_stat.load),
    .widths_i     (widths),
    .period_top_i (top_q),
    .timeout_i    (timeout_q),
    .pins_o       (pins),
    .alive_d_o    (alive_d)
  );

  // Pack the result beat
  logic [OUT_DW-1:0] res_data;
  logic              res_user;

  always_comb begin
    res_data                   = '0;
    res_data[BYTE_W-1:0]       = rx_stat.reply_byte;
    res_data[BYTE_W+:CHANNELS] = pins;
    res_data[BYTE_W+CHANNELS]  = ctrl_bit_d && alive_d;
    res_user                   = rx_stat.reply_valid;
  end

  // Output register plus skid entry
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  logic [OUT_DW-1:0] out_data_q, out_data_d, skid_data_q, skid_data_d;
  logic              out_user_q, out_user_d, skid_user_q, skid_user_d;
  logic              pop;

  assign s_axis_tready = !skid_valid_q;
  assign pop           = out_valid_q && m_axis_tready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    skid_user_d  = skid_user_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        out_user_d   = skid_user_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = step;
        out_data_d  = res_data;
        out_user_d  = res_user;
      end
    end else if (step) begin
      skid_valid_d = 1'b1;
      skid_data_d  = res_data;
      skid_user_d  = res_user;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_user_q  <= out_user_d;
    skid_data_q <= skid_data_d;
    skid_user_q <= skid_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `ISPWM_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_q || out_valid_q,
                       "skid entry held with empty output register")
  `ISPWM_ASSERT(a_no_reply_zero, out_valid_q && !out_user_q |-> out_data_q[BYTE_W-1:0] == '0,
                "reply byte nonzero without a reply")
  `ISPWM_ASSERT(a_reply_code,
                out_valid_q && out_user_q |->
                  (out_data_q[BYTE_W-1:0] == REPLY_GOOD) ||
                  (out_data_q[BYTE_W-1:0] == REPLY_BAD),
                "reply byte is neither good nor bad code")

endmodule

[tb/servo_mux_checker.sv]
// Checker for the servo PWM mux: predicts each result beat and compares it field by field.
`timescale 1ns / 1ps

module servo_mux_checker import ispwm_pkg::*; #(
  parameter int M_W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [BYTE_W-1:0]     s_tdata_i,
  input  logic [OP_W-1:0]       s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [M_W-1:0]        m_tdata_i,
  input  logic                  m_tuser_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    good_replies_o,
  output int                    bad_replies_o
);

  localparam int CHANNELS   = CHANNELS_DEF;
  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam int PKT_LEN    = CHANNELS + 2;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;

  typedef struct packed {
    logic                reply_valid;
    logic [BYTE_W-1:0]   reply_byte;
    logic [CHANNELS-1:0] pins;
    logic                radio_off;
  } servo_result_t;

  // Register copies
  logic [DEV_ADDR_W-1:0] dev_addr;
  logic [TIMEOUT_W-1:0]  timeout_lim;
  logic [TOP_W-1:0]      top_cnt;
  logic [BASE_W-1:0]     base_w;
  logic [SPAN_W-1:0]     span_w;

  // Receiver and PWM state
  int unsigned           pkt_pos;
  bit                    rx_open;
  logic [BYTE_W-1:0]     pkt_buf [PKT_LEN];
  logic [BYTE_W-1:0]     xor_acc;
  logic [COUNT_BITS-1:0] tick_cnt;
  logic [CHANNELS-1:0]   pin_lvl;
  logic [COUNT_BITS-1:0] live_width [CHANNELS];
  logic [COUNT_BITS-1:0] next_width [CHANNELS];
  logic [TIMEOUT_W-1:0]  since_good;

  servo_result_t         servo_results_due[$];

  // Pulse width for one channel byte, clipped to the counter range
  function automatic logic [COUNT_BITS-1:0] pulse_width_of(input logic [BYTE_W-1:0] v);
    longint unsigned w;
    w = longint'(base_w) + ((longint'(v) * longint'(span_w)) >> 8);
    if (w > COUNT_MAX) w = COUNT_MAX;
    return w[COUNT_BITS-1:0];
  endfunction

  // Apply one input beat to the shadow state and return the result it causes
  task automatic advance_servo_state(input op_e op, input logic [BYTE_W-1:0] b,
                                     output servo_result_t r);
    int i;
    r = '0;
    r.pins = pin_lvl;
    case (op)
      OP_TICK: begin
        tick_cnt = tick_cnt + 1'b1;
        for (i = 0; i < CHANNELS; i++) begin
          if (tick_cnt == live_width[i]) pin_lvl[i] = 1'b0;
        end
        if (tick_cnt == COUNT_BITS'(top_cnt)) begin
          pin_lvl = '1;
          for (i = 0; i < CHANNELS; i++) live_width[i] = next_width[i];
          tick_cnt = '0;
        end
        if (since_good != SINCE_MAX) since_good = since_good + 1'b1;
      end
      OP_ADDR_WR: begin
        pkt_pos = 0;
        if (b == {dev_addr, 1'b0}) rx_open = 1'b1;
      end
      OP_ADDR_RD: begin
        if (rx_open) begin
          r.reply_valid = 1'b1;
          if (xor_acc == pkt_buf[PKT_LEN-1]) begin
            since_good = '0;
            for (i = 0; i < CHANNELS; i++) next_width[i] = pulse_width_of(pkt_buf[i+1]);
            r.reply_byte = REPLY_GOOD;
            good_replies_o++;
          end else begin
            r.reply_byte = REPLY_BAD;
            bad_replies_o++;
          end
          rx_open = 1'b0;
          pkt_pos = PKT_LEN;
        end
      end
      default: begin
        // data byte: drop anything past the checksum
        if (rx_open && pkt_pos < PKT_LEN) begin
          pkt_buf[pkt_pos] = b;
          if (pkt_pos == 0) xor_acc = b;
          else if (pkt_pos < PKT_LEN - 1) xor_acc = xor_acc ^ b;
          pkt_pos++;
        end
      end
    endcase
    r.radio_off = pkt_buf[0][RADIO_BIT] && (since_good < timeout_lim);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t ns: result %0d %s expected %0h actual %0h",
               $time, results_o, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    servo_result_t want;
    servo_result_t got;
    int i;
    if (!rst_ni) begin
      dev_addr    = DEV_ADDR_RST;
      timeout_lim = TIMEOUT_RST;
      top_cnt     = TOP_RST;
      base_w      = BASE_RST;
      span_w      = SPAN_RST;
      pkt_pos     = 0;
      rx_open     = 1'b0;
      xor_acc     = '0;
      tick_cnt    = '0;
      pin_lvl     = '1;
      since_good  = '0;
      for (i = 0; i < PKT_LEN; i++) pkt_buf[i] = '0;
      for (i = 0; i < CHANNELS; i++) begin
        live_width[i] = '0;
        next_width[i] = '0;
      end
      servo_results_due.delete();
      fail_count_o   = 0;
      results_o      = 0;
      good_replies_o = 0;
      bad_replies_o  = 0;
    end else begin
      // Register write beat
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DEV_ADDR: dev_addr    = cfg_data_i[DEV_ADDR_W-1:0];
          CFG_TIMEOUT:  timeout_lim = cfg_data_i[TIMEOUT_W-1:0];
          CFG_TOP:      top_cnt     = cfg_data_i[TOP_W-1:0];
          CFG_BASE:     base_w      = cfg_data_i[BASE_W-1:0];
          CFG_SPAN:     span_w      = cfg_data_i[SPAN_W-1:0];
          default: ;
        endcase
      end
      // Compare the result beat before queueing this edge's input
      if (m_tvalid_i && m_tready_i) begin
        if (servo_results_due.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result %0d with nothing expected, tuser %0h tdata %0h",
                   $time, results_o, m_tuser_i, m_tdata_i);
        end else begin
          want            = servo_results_due.pop_front();
          got.reply_valid = m_tuser_i;
          got.reply_byte  = m_tdata_i[BYTE_W-1:0];
          got.pins        = m_tdata_i[BYTE_W +: CHANNELS];
          got.radio_off   = m_tdata_i[BYTE_W+CHANNELS];
          check_field("reply_valid", 32'(want.reply_valid), 32'(got.reply_valid));
          check_field("reply_byte", 32'(want.reply_byte), 32'(got.reply_byte));
          check_field("pwm_pins", 32'(want.pins), 32'(got.pins));
          check_field("radio_off", 32'(want.radio_off), 32'(got.radio_off));
          check_field("tdata padding", 32'd0, 32'(m_tdata_i[M_W-1:BYTE_W+CHANNELS+1]));
        end
        results_o++;
      end
      // Predict for the accepted input beat
      if (s_tvalid_i && s_tready_i) begin
        advance_servo_state(op_e'(s_tuser_i), s_tdata_i, want);
        servo_results_due.push_back(want);
      end
    end
    pending_o = servo_results_due.size();
  end

endmodule

[tb/tb_i2c_servo_pwm_mux.sv]
// Testbench top for the servo PWM mux: stimulus, register settings and verdict.
`timescale 1ns / 1ps

module tb_i2c_servo_pwm_mux;
  import ispwm_pkg::*;

  localparam int M_W        = ((BYTE_W + CHANNELS_DEF + 1 + 7) / 8) * 8;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 80;
  localparam int WRAP_TICKS = 40;
  localparam int QUIET_MAX  = 1000;

  typedef struct {
    logic [DEV_ADDR_W-1:0] dev;
    logic [TIMEOUT_W-1:0]  tmo;
    logic [TOP_W-1:0]      top;
    logic [BASE_W-1:0]     base;
    logic [SPAN_W-1:0]     span;
  } mux_cfg_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata;   // [7:0] bus_byte
  logic [OP_W-1:0]       s_axis_tuser;   // [1:0] operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_W-1:0]        m_axis_tdata;   // [7:0] reply_byte, [13:8] pwm_pins, [14] radio_off
  logic                  m_axis_tuser;   // [0] reply_valid
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int       fail_count;
  int       pending;
  int       results;
  int       good_replies;
  int       bad_replies;
  int       n_beats;
  int       n_wrap_beats;
  int       n_writes;
  int       n_settings;
  bit       idle_on;
  mux_cfg_t active_cfg;

  i2c_servo_pwm_mux u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  servo_mux_checker #(.M_W(M_W)) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tuser_i      (m_axis_tuser),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .good_replies_o (good_replies),
    .bad_replies_o  (bad_replies)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Result side: stall at random
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        hold = gap_len();
        m_axis_tready <= (hold == 0);
      end
    end
  end

  // Abort when no beat moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t ns: no beat accepted for %0d cycles", $time, QUIET_MAX);
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one beat after an optional gap and hold it until accepted
  task automatic send_beat(input op_e op, input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    n_beats++;
  endtask

  task automatic send_ticks(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) send_beat(OP_TICK, BYTE_W'($urandom));
  endtask

  // Write address, n data bytes with ticks mixed in, optional read address
  task automatic send_packet(input bit good_sum, input int unsigned n_data,
                             input logic [BYTE_W-1:0] addr_byte, input bit do_read);
    logic [BYTE_W-1:0] pkt [8];
    logic [BYTE_W-1:0] sum;
    int unsigned       i;
    sum = '0;
    for (i = 0; i < 7; i++) begin
      pkt[i] = BYTE_W'($urandom);
      sum    = sum ^ pkt[i];
    end
    pkt[7] = good_sum ? sum : sum ^ BYTE_W'($urandom_range(1, 255));
    send_beat(OP_ADDR_WR, addr_byte);
    for (i = 0; i < n_data; i++) begin
      if ($urandom_range(0, 4) == 0) send_ticks($urandom_range(1, 3));
      send_beat(OP_DATA, (i < 8) ? pkt[i] : BYTE_W'($urandom));
    end
    if (do_read) send_beat(OP_ADDR_RD, BYTE_W'($urandom));
  endtask

  // Let every expected result come back, then a few quiet cycles
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_writes++;
  endtask

  // Write all registers while idle; junk above non-timeout register widths must be dropped
  task automatic apply_settings(input mux_cfg_t c);
    drain();
    write_reg(CFG_DEV_ADDR, {17'($urandom), c.dev});
    write_reg(CFG_TIMEOUT, c.tmo);
    write_reg(CFG_TOP, {8'($urandom), c.top});
    write_reg(CFG_BASE, {8'($urandom), c.base});
    write_reg(CFG_SPAN, {8'($urandom), c.span});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    active_cfg = c;
    n_settings++;
  endtask

  initial begin : stimulus
    mux_cfg_t          c;
    logic [BYTE_W-1:0] dir_bytes [8];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] my_addr;
    int unsigned       pick;
    int                k;
    int                i;
    int                phase_end;

    n_beats       = 0;
    n_wrap_beats  = 0;
    n_writes      = 0;
    n_settings    = 0;
    idle_on       = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_TICK;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_DEV_ADDR;
    cfg_data_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: top address, short period, width = 1 + value
    c.dev  = 7'd127;
    c.tmo  = 24'd3;
    c.top  = 16'd4;
    c.base = 16'd1;
    c.span = 16'd256;
    apply_settings(c);
    my_addr = {c.dev, 1'b0};
    dir_bytes[0] = 8'h01;
    dir_bytes[1] = 8'h00;
    dir_bytes[2] = 8'hFF;
    dir_bytes[3] = 8'h01;
    dir_bytes[4] = 8'h02;
    dir_bytes[5] = 8'h80;
    dir_bytes[6] = 8'h7F;
    sum = '0;
    for (i = 0; i < 7; i++) sum = sum ^ dir_bytes[i];
    dir_bytes[7] = sum;
    // read and data while not receiving, then a wrong write address
    send_beat(OP_ADDR_RD, 8'h00);
    send_beat(OP_DATA, 8'h55);
    send_beat(OP_ADDR_WR, 8'hFF);
    // good packet with one byte past the checksum, read twice
    send_beat(OP_ADDR_WR, my_addr);
    for (i = 0; i < 8; i++) send_beat(OP_DATA, dir_bytes[i]);
    send_beat(OP_DATA, 8'hAA);
    send_beat(OP_ADDR_RD, 8'hFF);
    send_beat(OP_ADDR_RD, 8'h00);
    // load at period top, drop pins, run past the timeout
    send_ticks(6);
    // short packet
    send_beat(OP_ADDR_WR, my_addr);
    send_beat(OP_DATA, 8'h00);
    send_beat(OP_DATA, 8'hFF);
    send_beat(OP_DATA, 8'h3C);
    send_beat(OP_ADDR_RD, 8'h00);

    // Random phases: low extremes, rising small periods, high extremes, fully random
    for (k = 0; k < PHASES; k++) begin
      if (k == 0) begin
        c.dev  = '0;
        c.tmo  = 24'd1;
        c.top  = 16'd2;
        c.base = '0;
        c.span = '0;
      end else if (k == PHASES - 2) begin
        c.dev  = '1;
        c.tmo  = '1;
        c.top  = '1;
        c.base = '1;
        c.span = '1;
      end else if (k == PHASES - 1) begin
        c.dev  = DEV_ADDR_W'($urandom);
        c.tmo  = TIMEOUT_W'($urandom_range(1, 24'hFFFFFF));
        c.top  = TOP_W'($urandom_range(2, 16'hFFFF));
        c.base = BASE_W'($urandom);
        c.span = SPAN_W'($urandom);
      end else begin
        c.dev  = DEV_ADDR_W'($urandom);
        c.tmo  = TIMEOUT_W'($urandom_range(2, 60));
        c.top  = TOP_W'($urandom_range(6 + 9 * k, 14 + 9 * k));
        c.base = BASE_W'($urandom_range(0, c.top / 2));
        c.span = SPAN_W'($urandom_range(0, c.top * 256));
      end
      apply_settings(c);
      my_addr   = {active_cfg.dev, 1'b0};
      phase_end = n_beats + PHASE_LEN;
      while (n_beats < phase_end) begin
        idle_on = ($urandom_range(0, 4) != 0);
        pick    = $urandom_range(0, 99);
        if (pick < 50) begin
          send_packet(($urandom_range(0, 4) != 0),
                      ($urandom_range(0, 9) == 0) ? 8 + $urandom_range(1, 3) : 8,
                      my_addr, 1'b1);
        end else if (pick < 78) begin
          send_ticks($urandom_range(1, 40));
        end else if (pick < 90) begin
          send_packet(1'($urandom_range(0, 1)), $urandom_range(0, 10),
                      $urandom_range(0, 1) ? my_addr : BYTE_W'($urandom),
                      1'($urandom_range(0, 1)));
        end else begin
          send_beat(op_e'($urandom_range(0, 3)), BYTE_W'($urandom));
        end
      end
    end

    // Saturated widths near the counter top, then a period top below the count
    idle_on = 1'b0;
    c       = active_cfg;
    c.top   = '1;
    c.base  = 16'd65000;
    c.span  = '1;
    apply_settings(c);
    i = n_beats;
    send_packet(1'b1, 8, {c.dev, 1'b0}, 1'b1);
    send_ticks(WRAP_TICKS);
    c.top = 16'd2;
    apply_settings(c);
    send_ticks(WRAP_TICKS);
    n_wrap_beats = n_beats - i;

    drain();
    $display("Covered %0d input beats (%0d in the closing saturation pass) over %0d settings",
             n_beats, n_wrap_beats, n_settings);
    $display("with %0d register writes; %0d results checked, %0d good and %0d bad replies",
             n_writes, results, good_replies, bad_replies);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
